@@ rtl/core/wtlrp_pkg.sv @@
// shared types, constants and the level selection function of the ready picker
package wtlrp_pkg;

  localparam int LEVELS      = 3;
  localparam int LVL_W       = 2;
  localparam int TID_W       = 8;
  localparam int DRAW_W      = 5;
  localparam int THR_W       = 5;
  localparam int MAX_ID_BITS = 16;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [THR_W-1:0] LOW_THR_RESET = 5'd4;
  localparam logic [THR_W-1:0] MID_THR_RESET = 5'd10;

  localparam logic [LVL_W-1:0] LVL_0 = 2'd0;
  localparam logic [LVL_W-1:0] LVL_1 = 2'd1;
  localparam logic [LVL_W-1:0] LVL_2 = 2'd2;

  typedef enum logic {
    REG_LOW_THR = 1'b0,
    REG_MID_THR = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic             found;
    logic [LVL_W-1:0] level;
  } pick_t;

  // try order follows the draw band, first non-empty queue wins
  function automatic pick_t pick_level(input logic lt_low, input logic lt_mid,
                                       input logic [LEVELS-1:0] ne);
    logic [LVL_W-1:0] o0;
    logic [LVL_W-1:0] o1;
    logic [LVL_W-1:0] o2;
    pick_t            p;
    if (lt_low) begin
      o0 = LVL_2; o1 = LVL_1; o2 = LVL_0;
    end else if (lt_mid) begin
      o0 = LVL_1; o1 = LVL_0; o2 = LVL_2;
    end else begin
      o0 = LVL_2; o1 = LVL_0; o2 = LVL_1;
    end
    p.found = 1'b1;
    if (ne[o0]) begin
      p.level = o0;
    end else if (ne[o1]) begin
      p.level = o1;
    end else if (ne[o2]) begin
      p.level = o2;
    end else begin
      p.found = 1'b0;
      p.level = LVL_0;
    end
    return p;
  endfunction

endpackage

@@ rtl/core/wtlrp_cfg.sv @@
// threshold registers behind the apb port
module wtlrp_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wtlrp_pkg::APB_AW-1:0]      paddr,
  input  logic [wtlrp_pkg::APB_DW-1:0]      pwdata,
  output logic [wtlrp_pkg::APB_DW-1:0]      prdata,
  output logic                              pready,
  output logic [wtlrp_pkg::THR_W-1:0]       low_thr,
  output logic [wtlrp_pkg::THR_W-1:0]       mid_thr
);

  wtlrp_pkg::reg_idx_t idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign idx    = wtlrp_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr <= wtlrp_pkg::LOW_THR_RESET;
      mid_thr <= wtlrp_pkg::MID_THR_RESET;
    end else if (wr_en) begin
      unique case (idx)
        wtlrp_pkg::REG_LOW_THR: low_thr <= pwdata[wtlrp_pkg::THR_W-1:0];
        wtlrp_pkg::REG_MID_THR: mid_thr <= pwdata[wtlrp_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      wtlrp_pkg::REG_LOW_THR: prdata = wtlrp_pkg::APB_DW'(low_thr);
      wtlrp_pkg::REG_MID_THR: prdata = wtlrp_pkg::APB_DW'(mid_thr);
      default:                prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/wtlrp_ctrl.sv @@
// controller state machine: request intake, decide step and result hand-off
module wtlrp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output wtlrp_pkg::dp_cmd_t cmd
);

  wtlrp_pkg::state_t state;
  wtlrp_pkg::state_t state_next;
  logic              out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wtlrp_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.decide  = 1'b0;
    cmd.load    = 1'b0;
    unique case (state)
      wtlrp_pkg::S_IDLE: begin
        in_stall    = rst;
        cmd.capture = in_valid && !rst;
        if (in_valid) begin
          state_next = wtlrp_pkg::S_DECIDE;
        end
      end
      wtlrp_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = wtlrp_pkg::S_FINISH;
      end
      wtlrp_pkg::S_FINISH: begin
        // result goes out and the next request comes in on the same edge
        if (out_free) begin
          cmd.load    = 1'b1;
          in_stall    = rst;
          cmd.capture = in_valid && !rst;
          state_next  = in_valid ? wtlrp_pkg::S_DECIDE : wtlrp_pkg::S_IDLE;
        end
      end
      default: state_next = wtlrp_pkg::S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/wtlrp_dp.sv @@
// datapath: request registers, queue memory, pointers, occupancy and result register
module wtlrp_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wtlrp_pkg::dp_cmd_t               cmd,
  input  logic                             operation,
  input  logic [wtlrp_pkg::LVL_W-1:0]      level,
  input  logic [wtlrp_pkg::TID_W-1:0]      thread_id,
  input  logic [wtlrp_pkg::DRAW_W-1:0]     draw,
  input  logic [wtlrp_pkg::THR_W-1:0]      low_thr,
  input  logic [wtlrp_pkg::THR_W-1:0]      mid_thr,
  output logic [1:0]                       status,
  output logic [wtlrp_pkg::TID_W-1:0]      chosen_id,
  output logic [wtlrp_pkg::LVL_W-1:0]      served_level
);

  localparam int PW        = $clog2(QUEUE_DEPTH);
  localparam int OW        = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = wtlrp_pkg::LEVELS * QUEUE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);

  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [OW-1:0] OCC_FULL = OW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] BASE_1   = AW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] BASE_2   = AW'(2 * QUEUE_DEPTH);

  logic [ID_BITS-1:0] mem [MEM_DEPTH];
  logic [ID_BITS-1:0] rd_data;

  logic [PW-1:0] rd_ptr [wtlrp_pkg::LEVELS];
  logic [PW-1:0] wr_ptr [wtlrp_pkg::LEVELS];
  logic [OW-1:0] occ    [wtlrp_pkg::LEVELS];

  wtlrp_pkg::op_t                op_q;
  logic [wtlrp_pkg::LVL_W-1:0]   lvl_q;
  logic [wtlrp_pkg::TID_W-1:0]   tid_q;
  logic [wtlrp_pkg::DRAW_W-1:0]  draw_q;

  wtlrp_pkg::status_t            res_status;
  logic [wtlrp_pkg::LVL_W-1:0]   res_served;
  logic                          res_pop;
  wtlrp_pkg::status_t            status_q;

  logic [wtlrp_pkg::LEVELS-1:0]  ne;
  wtlrp_pkg::pick_t              sel;
  logic [wtlrp_pkg::LVL_W-1:0]   tgt;
  logic                          full;
  logic                          do_push;
  logic                          do_pop;
  logic [PW-1:0]                 ptr;
  logic [PW-1:0]                 ptr_inc;
  logic [AW-1:0]                 base;
  logic [AW-1:0]                 addr;
  logic [wtlrp_pkg::MAX_ID_BITS-1:0] tid_wide;
  logic [ID_BITS-1:0]            wdata;
  logic [wtlrp_pkg::MAX_ID_BITS-1:0] rd_wide;

  assign tid_wide = wtlrp_pkg::MAX_ID_BITS'(tid_q);
  assign wdata    = tid_wide[ID_BITS-1:0];
  assign rd_wide  = wtlrp_pkg::MAX_ID_BITS'(rd_data);

  always_comb begin
    for (int i = 0; i < wtlrp_pkg::LEVELS; i++) begin
      ne[i] = occ[i] != '0;
    end
    sel     = wtlrp_pkg::pick_level(draw_q < low_thr, draw_q < mid_thr, ne);
    tgt     = (op_q == wtlrp_pkg::OP_PICK) ? sel.level : lvl_q;
    full    = occ[tgt] == OCC_FULL;
    do_push = (op_q == wtlrp_pkg::OP_PUSH) && !full;
    do_pop  = (op_q == wtlrp_pkg::OP_PICK) && sel.found;
    ptr     = (op_q == wtlrp_pkg::OP_PUSH) ? wr_ptr[tgt] : rd_ptr[tgt];
    ptr_inc = (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
    case (tgt)
      wtlrp_pkg::LVL_1: base = BASE_1;
      wtlrp_pkg::LVL_2: base = BASE_2;
      default:          base = '0;
    endcase
    addr = base + AW'(ptr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wtlrp_pkg::LEVELS; i++) begin
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
        occ[i]    <= '0;
      end
    end else if (cmd.decide) begin
      if (do_push) begin
        wr_ptr[tgt] <= ptr_inc;
        occ[tgt]    <= occ[tgt] + 1'b1;
      end
      if (do_pop) begin
        rd_ptr[tgt] <= ptr_inc;
        occ[tgt]    <= occ[tgt] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (do_push) begin
        mem[addr] <= wdata;
      end
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= wtlrp_pkg::op_t'(operation);
      // level three saturates to level two
      lvl_q  <= (level > wtlrp_pkg::LVL_2) ? wtlrp_pkg::LVL_2 : level;
      tid_q  <= thread_id;
      draw_q <= draw;
    end
    if (cmd.decide) begin
      res_pop <= do_pop;
      if (op_q == wtlrp_pkg::OP_PUSH) begin
        res_status <= full ? wtlrp_pkg::ST_FULL : wtlrp_pkg::ST_DONE;
        res_served <= lvl_q;
      end else begin
        res_status <= sel.found ? wtlrp_pkg::ST_DONE : wtlrp_pkg::ST_EMPTY;
        res_served <= sel.level;
      end
    end
    if (cmd.load) begin
      status_q     <= res_status;
      served_level <= res_served;
      chosen_id    <= res_pop ? rd_wide[wtlrp_pkg::TID_W-1:0] : '0;
    end
  end

  assign status = status_q;

endmodule

@@ rtl/core/weighted_three_level_ready_picker_top.sv @@
// top level of the three-level ready picker
// Three FIFO ready queues of thread ids, one per priority level, sharing one
// queue memory of 3*QUEUE_DEPTH entries. A push request appends an id to its
// level (level three counts as two) or reports full; a pick request uses its
// draw and the two threshold registers to choose a try order and pops the
// head of the first non-empty queue, or reports all empty. Each request passes
// through a decide state that updates the pointers and does the single queue
// memory access, then a finish state that loads the output register and takes
// the next request on the same edge. A stalled output holds the block in the
// finish state. Thresholds sit at byte addresses 0 and 4; the user must write
// them only while no request is in flight, and the block does not enforce it.
module weighted_three_level_ready_picker_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             operation,
  input  logic [wtlrp_pkg::LVL_W-1:0]      level,
  input  logic [wtlrp_pkg::TID_W-1:0]      thread_id,
  input  logic [wtlrp_pkg::DRAW_W-1:0]     draw,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [wtlrp_pkg::TID_W-1:0]      chosen_id,
  output logic [wtlrp_pkg::LVL_W-1:0]      served_level,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wtlrp_pkg::APB_AW-1:0]     paddr,
  input  logic [wtlrp_pkg::APB_DW-1:0]     pwdata,
  output logic [wtlrp_pkg::APB_DW-1:0]     prdata,
  output logic                             pready
);

  wtlrp_pkg::dp_cmd_t             cmd;
  logic [wtlrp_pkg::THR_W-1:0]    low_thr;
  logic [wtlrp_pkg::THR_W-1:0]    mid_thr;

  wtlrp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .low_thr (low_thr),
    .mid_thr (mid_thr)
  );

  wtlrp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  wtlrp_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .operation    (operation),
    .level        (level),
    .thread_id    (thread_id),
    .draw         (draw),
    .low_thr      (low_thr),
    .mid_thr      (mid_thr),
    .status       (status),
    .chosen_id    (chosen_id),
    .served_level (served_level)
  );

endmodule

@@ rtl/core/wtlrp_checker.sv @@
// port-level checks of the ready picker and their bind
module wtlrp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    status,
  input logic [wtlrp_pkg::TID_W-1:0]   chosen_id,
  input logic [wtlrp_pkg::LVL_W-1:0]   served_level
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(chosen_id))
    else $error("stalled result changed or dropped");

  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3 && served_level != 2'd3)
    else $error("status or level code out of range");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == wtlrp_pkg::ST_EMPTY |-> chosen_id == '0 && served_level == '0)
    else $error("empty pick carries an id or level");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == wtlrp_pkg::ST_FULL |-> chosen_id == '0)
    else $error("refused push carries an id");

endmodule

bind weighted_three_level_ready_picker_top wtlrp_checker u_wtlrp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .chosen_id    (chosen_id),
  .served_level (served_level)
);

@@ dv/ready_picker_sb_pkg.sv @@
// scoreboard for the three-level ready picker: queue predictor and result checker
`timescale 1ns / 1ps
package ready_picker_sb_pkg;
  import wtlrp_pkg::*;

  localparam int QDEPTH = 16;

  typedef struct packed {
    status_t          st;
    logic [TID_W-1:0] id;
    logic [LVL_W-1:0] lv;
  } pick_result_t;

  class ready_picker_scoreboard;
    logic [THR_W-1:0] low_thr;
    logic [THR_W-1:0] mid_thr;
    logic [TID_W-1:0] ready_q [LEVELS][$];
    pick_result_t     due_results [$];
    int               mismatches;
    int               n_checked;
    int               n_push;
    int               n_pick;
    int               n_full;
    int               n_empty;
    int               n_band [3];

    function new();
      low_thr    = LOW_THR_RESET;
      mid_thr    = MID_THR_RESET;
      mismatches = 0;
      n_checked  = 0;
      n_push     = 0;
      n_pick     = 0;
      n_full     = 0;
      n_empty    = 0;
      n_band     = '{0, 0, 0};
    endfunction

    function void set_threshold(reg_idx_t idx, logic [THR_W-1:0] v);
      if (idx == REG_LOW_THR) begin
        low_thr = v;
      end else begin
        mid_thr = v;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void register_check(reg_idx_t idx, logic [THR_W-1:0] got);
      logic [THR_W-1:0] want;
      want = (idx == REG_LOW_THR) ? low_thr : mid_thr;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("register %s read back: expected %0d, got %0d", idx.name(), want, got);
        end
      end
    endfunction

    // works out the result of one accepted request and updates the queues
    function void note_request(op_t op, logic [LVL_W-1:0] lvl, logic [TID_W-1:0] tid,
                               logic [DRAW_W-1:0] drw);
      pick_result_t     r;
      logic [LVL_W-1:0] l;
      logic [LVL_W-1:0] order [3];
      r.st = ST_DONE;
      r.id = '0;
      r.lv = LVL_0;
      if (op == OP_PUSH) begin
        n_push++;
        // level three saturates to two
        l = (lvl > LVL_2) ? LVL_2 : lvl;
        r.lv = l;
        if (ready_q[l].size() >= QDEPTH) begin
          r.st = ST_FULL;
          n_full++;
        end else begin
          ready_q[l].insert(ready_q[l].size(), tid);
        end
      end else begin
        n_pick++;
        if (drw < low_thr) begin
          order = '{LVL_2, LVL_1, LVL_0};
          n_band[0]++;
        end else if (drw < mid_thr) begin
          order = '{LVL_1, LVL_0, LVL_2};
          n_band[1]++;
        end else begin
          order = '{LVL_2, LVL_0, LVL_1};
          n_band[2]++;
        end
        r.st = ST_EMPTY;
        for (int k = 0; k < 3; k++) begin
          if (r.st == ST_EMPTY && ready_q[order[k]].size() != 0) begin
            r.st = ST_DONE;
            r.id = ready_q[order[k]][0];
            ready_q[order[k]].delete(0);
            r.lv = order[k];
          end
        end
        if (r.st == ST_EMPTY) begin
          n_empty++;
        end
      end
      due_results.insert(due_results.size(), r);
    endfunction

    function void check_result(logic [1:0] st, logic [TID_W-1:0] id, logic [LVL_W-1:0] lv);
      pick_result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result with nothing expected: status %0d id %0d level %0d", st, id, lv);
        end
        return;
      end
      want = due_results[0];
      due_results.delete(0);
      n_checked++;
      if (st !== want.st || id !== want.id || lv !== want.lv) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d: expected status %0d id %0d level %0d,",
                   n_checked, want.st, want.id, want.lv);
          $display("  got status %0d id %0d level %0d", st, id, lv);
        end
      end
    endfunction
  endclass

endpackage

@@ dv/testbench.sv @@
// testbench top for the three-level ready picker
`timescale 1ns / 1ps
module testbench;
  import wtlrp_pkg::*;
  import ready_picker_sb_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              operation = OP_PUSH;
  logic [LVL_W-1:0]  level = '0;
  logic [TID_W-1:0]  thread_id = '0;
  logic [DRAW_W-1:0] draw = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic [TID_W-1:0]  chosen_id;
  logic [LVL_W-1:0]  served_level;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ready_picker_scoreboard sb;
  int idle_pct = 0;
  bit calm = 1'b0;
  int stall_left = 0;
  int n_settings = 0;

  weighted_three_level_ready_picker_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .level(level), .thread_id(thread_id), .draw(draw),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .chosen_id(chosen_id), .served_level(served_level),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver stalls in bursts of random length
  always @(negedge clk) begin
    if (rst || calm) begin
      out_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(status, chosen_id, served_level);
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_request(input op_t op, input logic [LVL_W-1:0] lvl,
                              input logic [TID_W-1:0] tid, input logic [DRAW_W-1:0] drw);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    operation = op;
    level = lvl;
    thread_id = tid;
    draw = drw;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(op, lvl, tid, drw);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    int guard;
    in_valid = 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [THR_W-1:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = APB_AW'(int'(idx) * 4);
    // upper bits are junk, only the low five count
    pwdata = ($urandom & ~32'h1f) | APB_DW'(v);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_threshold(idx, v);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_read_check(input reg_idx_t idx);
    logic [APB_DW-1:0] got;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = APB_AW'(int'(idx) * 4);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    sb.register_check(idx, got[THR_W-1:0]);
  endtask

  task automatic set_thresholds(input logic [THR_W-1:0] lo, input logic [THR_W-1:0] mi);
    wait_all_results();
    apb_write(REG_LOW_THR, lo);
    apb_write(REG_MID_THR, mi);
    apb_read_check(REG_LOW_THR);
    apb_read_check(REG_MID_THR);
    n_settings++;
  endtask

  task automatic run_random(input int n_items, input bit pause_midway);
    int               push_pct;
    int               fav;
    op_t              op;
    logic [LVL_W-1:0] lvl;
    logic [DRAW_W-1:0] drw;
    push_pct = 50;
    fav = 0;
    for (int i = 0; i < n_items; i++) begin
      // change the push/pick mix in bursts so queues fill up and drain out
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 15;
          1: push_pct = 50;
          2: push_pct = 75;
          default: push_pct = 95;
        endcase
        fav = $urandom_range(0, 2);
      end
      if (pause_midway && i == n_items / 2) begin
        wait_all_results();
      end
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_PICK;
      if ($urandom_range(0, 9) == 0) begin
        lvl = 2'd3;
      end else if ($urandom_range(0, 1) == 0) begin
        lvl = LVL_W'(fav);
      end else begin
        lvl = LVL_W'($urandom_range(0, 2));
      end
      if ($urandom_range(0, 9) == 0) begin
        drw = DRAW_W'($urandom_range(19, 31));
      end else begin
        drw = DRAW_W'($urandom_range(0, 18));
      end
      send_request(op, lvl, TID_W'($urandom), drw);
    end
  endtask

  initial begin
    int lo_set [8];
    int mi_set [8];
    int idle_set [8];
    sb = new();
    lo_set   = '{0, 19, 31, 12, 0, 7, 0, 4};
    mi_set   = '{0, 19, 31, 5, 19, 13, 0, 10};
    idle_set = '{20, 30, 0, 25, 40, 15, 30, 0};
    lo_set[6] = $urandom_range(0, 31);
    mi_set[6] = $urandom_range(0, 31);
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed part under the reset thresholds
    idle_pct = 20;
    send_request(OP_PICK, LVL_0, 8'd0, 5'd0);
    send_request(OP_PICK, LVL_2, 8'hff, 5'd31);
    send_request(OP_PUSH, LVL_0, 8'h00, 5'd0);
    send_request(OP_PUSH, LVL_1, 8'hff, 5'd31);
    send_request(OP_PUSH, LVL_2, 8'h5a, 5'd0);
    send_request(OP_PUSH, 2'd3, 8'ha5, 5'd18);
    send_request(OP_PICK, LVL_0, 8'd0, 5'd0);
    send_request(OP_PICK, LVL_0, 8'd0, 5'd3);
    send_request(OP_PICK, LVL_0, 8'd0, 5'd4);
    send_request(OP_PICK, LVL_0, 8'd0, 5'd9);
    send_request(OP_PICK, LVL_0, 8'd0, 5'd10);
    send_request(OP_PUSH, LVL_0, 8'h11, 5'd0);
    send_request(OP_PUSH, LVL_1, 8'h22, 5'd0);
    send_request(OP_PICK, LVL_0, 8'd0, 5'd10);
    send_request(OP_PICK, LVL_0, 8'd0, 5'd18);
    send_request(OP_PUSH, LVL_2, 8'h33, 5'd0);
    send_request(OP_PUSH, LVL_1, 8'h44, 5'd0);
    send_request(OP_PUSH, LVL_0, 8'h55, 5'd0);
    send_request(OP_PICK, 2'd3, 8'hff, 5'd31);
    send_request(OP_PICK, LVL_0, 8'd0, 5'd5);
    send_request(OP_PICK, LVL_0, 8'd0, 5'd19);
    send_request(OP_PICK, LVL_0, 8'd0, 5'd1);

    for (int p = 0; p < 8; p++) begin
      set_thresholds(THR_W'(lo_set[p]), THR_W'(mi_set[p]));
      idle_pct = idle_set[p];
      calm = (p == 7);
      run_random(210, p == 3);
    end

    wait_all_results();
    repeat (8) @(negedge clk);
    $display("covered %0d pushes (%0d refused as full) and %0d picks (%0d on empty queues)",
             sb.n_push, sb.n_full, sb.n_pick, sb.n_empty);
    $display("draw bands hit %0d/%0d/%0d over %0d threshold settings, %0d results compared",
             sb.n_band[0], sb.n_band[1], sb.n_band[2], n_settings, sb.n_checked);
    if (sb.pending() != 0) begin
      $display("%0d expected results never arrived", sb.pending());
    end
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ weighted_three_level_ready_picker_top.f @@
rtl/core/wtlrp_pkg.sv
rtl/core/wtlrp_cfg.sv
rtl/core/wtlrp_ctrl.sv
rtl/core/wtlrp_dp.sv
rtl/core/weighted_three_level_ready_picker_top.sv
rtl/core/wtlrp_checker.sv
dv/ready_picker_sb_pkg.sv
dv/testbench.sv
